// File: rtl/mcpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle point generator package
// Shared types and constants for the circle step sequencer, step queue and
// point emitter.
// ----------------------------------------------------------------------------
package mcpg_pkg;

  // Opcode of an input word.
  localparam logic OpStart   = 1'b0;
  localparam logic OpAdvance = 1'b1;

  // Status of a result word.
  localparam logic StatusPoint = 1'b0;
  localparam logic StatusIdle  = 1'b1;

  // Field widths.
  localparam int CoordW    = 8;
  localparam int PointW    = 16;
  localparam int ColorW    = 16;
  localparam int DecisionW = 12;

  // Each loop step produces eight points.
  localparam int                 PointIdxW = 3;
  localparam logic [PointIdxW-1:0] LastPoint = 3'd7;

  // Step queue between the sequencer and the emitter.
  localparam int StepFifoDepth = 2;
  localparam int StepFifoPtrW  = 1;

  // One loop step as handed from the sequencer to the emitter.
  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ColorW-1:0] color;
    logic              done;
    logic              idle;
  } step_t;

endpackage

// File: rtl/mcpg_step_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step queue
// Short first-in first-out queue of loop steps between the sequencer and the
// point emitter.
// ----------------------------------------------------------------------------
module mcpg_step_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  mcpg_pkg::step_t wr_data_i,
  output logic            full_o,
  input  logic            rd_i,
  output mcpg_pkg::step_t rd_data_o,
  output logic            empty_o
);

  mcpg_pkg::step_t                        mem_q [mcpg_pkg::StepFifoDepth];
  logic [mcpg_pkg::StepFifoPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mcpg_pkg::StepFifoPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mcpg_pkg::StepFifoPtrW:0]        count_q, count_d;
  logic                                   do_wr, do_rd;

  assign full_o    = (count_q == (mcpg_pkg::StepFifoPtrW+1)'(mcpg_pkg::StepFifoDepth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  assign do_wr = wr_i & ~full_o;
  assign do_rd = rd_i & ~empty_o;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: rtl/mcpg_step_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle step sequencer
// Accepts start and advance words, keeps the circle state and issues one
// loop step (or an idle marker) per word into the step queue.
// ----------------------------------------------------------------------------
module mcpg_step_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          opcode_i,
  input  logic [mcpg_pkg::CoordW-1:0]   center_x_i,
  input  logic [mcpg_pkg::CoordW-1:0]   center_y_i,
  input  logic [mcpg_pkg::CoordW-1:0]   radius_i,
  input  logic [mcpg_pkg::ColorW-1:0]   color_i,
  input  logic                          q_full_i,
  output logic                          q_wr_o,
  output mcpg_pkg::step_t               q_step_o
);

  logic                              active_q, active_d;
  logic [mcpg_pkg::CoordW-1:0]       cx_q, cy_q, x_q, y_q;
  logic [mcpg_pkg::DecisionW-1:0]    dec_q;
  logic [mcpg_pkg::ColorW-1:0]       color_q;

  logic                              accept, start, cur_active, idle, dec_pos, done;
  logic [mcpg_pkg::CoordW-1:0]       cur_cx, cur_cy, cur_x, cur_y, nx, ny;
  logic [mcpg_pkg::DecisionW-1:0]    cur_dec, nd;
  logic [mcpg_pkg::ColorW-1:0]       cur_color;

  assign full   = q_full_i;
  assign accept = push & ~q_full_i;
  assign start  = (opcode_i == mcpg_pkg::OpStart);

  always_comb begin
    // A start word overrides the stored circle.
    cur_active = start | active_q;
    cur_cx     = start ? center_x_i : cx_q;
    cur_cy     = start ? center_y_i : cy_q;
    cur_x      = start ? '0 : x_q;
    cur_y      = start ? radius_i : y_q;
    cur_dec    = start ? (mcpg_pkg::DecisionW)'(12'd1 - {4'd0, radius_i}) : dec_q;
    cur_color  = start ? color_i : color_q;

    idle    = ~cur_active | (cur_x > cur_y);
    dec_pos = ~cur_dec[mcpg_pkg::DecisionW-1] & (cur_dec != '0);
    nx      = cur_x + 1'b1;
    ny      = dec_pos ? cur_y - 1'b1 : cur_y;
    if (dec_pos) begin
      nd = cur_dec + {3'd0, nx, 1'b0} - {3'd0, ny, 1'b0} + 12'd1;
    end else begin
      nd = cur_dec + {3'd0, nx, 1'b0} + 12'd1;
    end
    done = (nx > ny);

    active_d = active_q;
    if (accept) begin
      active_d = idle ? 1'b0 : ~done;
    end
  end

  assign q_wr_o         = accept;
  assign q_step_o.cx    = cur_cx;
  assign q_step_o.cy    = cur_cy;
  assign q_step_o.x     = cur_x;
  assign q_step_o.y     = cur_y;
  assign q_step_o.color = cur_color;
  assign q_step_o.done  = done;
  assign q_step_o.idle  = idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      dec_q    <= '0;
      color_q  <= '0;
    end else begin
      active_q <= active_d;
      if (accept && !idle) begin
        cx_q    <= cur_cx;
        cy_q    <= cur_cy;
        x_q     <= nx;
        y_q     <= ny;
        dec_q   <= nd;
        color_q <= cur_color;
      end
    end
  end

endmodule

// File: rtl/mcpg_point_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point emitter
// Expands each queued loop step into its eight symmetric points (an idle
// into one idle word), one per unstalled cycle, via a registered result stage.
// ----------------------------------------------------------------------------
module mcpg_point_emitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  mcpg_pkg::step_t               q_step_i,
  output logic                          q_rd_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [mcpg_pkg::PointW-1:0]   point_x_o,
  output logic [mcpg_pkg::PointW-1:0]   point_y_o,
  output logic [mcpg_pkg::ColorW-1:0]   pixel_color_o,
  output logic                          last_of_step_o,
  output logic                          circle_done_o,
  output logic                          status_o
);

  logic                              out_valid_q;
  logic [mcpg_pkg::PointIdxW-1:0]    idx_q;
  logic [mcpg_pkg::PointW-1:0]       px_q, py_q;
  logic [mcpg_pkg::ColorW-1:0]       color_q;
  logic                              last_q, done_q, status_q;

  logic                              load, last;
  logic [mcpg_pkg::CoordW-1:0]       off_a, off_b;
  logic [mcpg_pkg::PointW-1:0]       ext_cx, ext_cy, ext_a, ext_b, px_d, py_d;

  assign load   = ~q_empty_i & (~out_valid_q | pop);
  assign last   = q_step_i.idle | (idx_q == mcpg_pkg::LastPoint);
  assign q_rd_o = load & last;

  // Index bit 2 swaps the offsets, bit 0 negates the column offset and
  // bit 1 negates the row offset.
  always_comb begin
    off_a  = idx_q[2] ? q_step_i.y : q_step_i.x;
    off_b  = idx_q[2] ? q_step_i.x : q_step_i.y;
    ext_cx = {8'd0, q_step_i.cx};
    ext_cy = {8'd0, q_step_i.cy};
    ext_a  = {8'd0, off_a};
    ext_b  = {8'd0, off_b};
    px_d   = idx_q[0] ? ext_cx - ext_a : ext_cx + ext_a;
    py_d   = idx_q[1] ? ext_cy - ext_b : ext_cy + ext_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? '0 : idx_q + 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (q_step_i.idle) begin
        px_q     <= '0;
        py_q     <= '0;
        color_q  <= '0;
        last_q   <= 1'b1;
        done_q   <= 1'b0;
        status_q <= mcpg_pkg::StatusIdle;
      end else begin
        px_q     <= px_d;
        py_q     <= py_d;
        color_q  <= q_step_i.color;
        last_q   <= last;
        done_q   <= q_step_i.done;
        status_q <= mcpg_pkg::StatusPoint;
      end
    end
  end

  assign empty          = ~out_valid_q;
  assign point_x_o      = px_q;
  assign point_y_o      = py_q;
  assign pixel_color_o  = color_q;
  assign last_of_step_o = last_q;
  assign circle_done_o  = done_q;
  assign status_o       = status_q;

endmodule

// File: rtl/midpoint_circle_point_generator.sv
`timescale 1ns / 1ps
// Path: an accepted input word is written into the step queue; at the
//   queue head it loads the registered result stage when that is empty or popped.
// Output: a step word yields eight point words at one word per cycle while
//   pop keeps up; an idle advance yields one idle word.
// Reset: rst_ni clears the circle state, the step queue and the result stage.
// ----------------------------------------------------------------------------
// Midpoint circle point generator
// Rasterizes circles with the midpoint rule, eight symmetric points per step.
// ----------------------------------------------------------------------------
module midpoint_circle_point_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input queue side.
  input  logic                          push,
  output logic                          full,
  input  logic                          opcode_i,
  input  logic [mcpg_pkg::CoordW-1:0]   center_x_i,
  input  logic [mcpg_pkg::CoordW-1:0]   center_y_i,
  input  logic [mcpg_pkg::CoordW-1:0]   radius_i,
  input  logic [mcpg_pkg::ColorW-1:0]   color_i,
  // Result queue side.
  output logic                          empty,
  input  logic                          pop,
  output logic [mcpg_pkg::PointW-1:0]   point_x_o,
  output logic [mcpg_pkg::PointW-1:0]   point_y_o,
  output logic [mcpg_pkg::ColorW-1:0]   pixel_color_o,
  output logic                          last_of_step_o,
  output logic                          circle_done_o,
  output logic                          status_o
);

  // The sequencer owns the circle state. Every accepted word is turned at
  // once into one step descriptor: center, current x and y offsets, color,
  // whether this is the final step, and whether the word was an advance with
  // no circle in progress. The state advances in the same cycle, so the next
  // word can be taken right away as long as the queue has room.
  logic            q_wr, q_full, q_rd, q_empty;
  mcpg_pkg::step_t q_wr_step, q_rd_step;

  mcpg_step_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .opcode_i   (opcode_i),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .radius_i   (radius_i),
    .color_i    (color_i),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr),
    .q_step_o   (q_wr_step)
  );

  // A two-entry queue decouples the sequencer from the emitter: while the
  // emitter works through the eight points of one step, the next step waits here and
  // the input side keeps moving until the queue fills.
  mcpg_step_fifo u_step_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_step),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_rd_step),
    .empty_o   (q_empty)
  );

  // The emitter walks the eight symmetric points of the head step in order
  // and releases the step after the eighth (an idle step after its one word).
  // Its result register loads whenever a step is queued and it is empty or
  // being popped, so a steady consumer sees one word per cycle.
  mcpg_point_emitter u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_step_i       (q_rd_step),
    .q_rd_o         (q_rd),
    .empty          (empty),
    .pop            (pop),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .pixel_color_o  (pixel_color_o),
    .last_of_step_o (last_of_step_o),
    .circle_done_o  (circle_done_o),
    .status_o       (status_o)
  );

endmodule

// File: verif/circle_point_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circle point monitor
// Watches both queue sides of the midpoint circle point generator, predicts
// the point words of every accepted input word and compares them in order.
// ----------------------------------------------------------------------------
module circle_point_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  logic                          full,
  input  logic                          opcode_i,
  input  logic [mcpg_pkg::CoordW-1:0]   center_x_i,
  input  logic [mcpg_pkg::CoordW-1:0]   center_y_i,
  input  logic [mcpg_pkg::CoordW-1:0]   radius_i,
  input  logic [mcpg_pkg::ColorW-1:0]   color_i,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [mcpg_pkg::PointW-1:0]   point_x_i,
  input  logic [mcpg_pkg::PointW-1:0]   point_y_i,
  input  logic [mcpg_pkg::ColorW-1:0]   pixel_color_i,
  input  logic                          last_of_step_i,
  input  logic                          circle_done_i,
  input  logic                          status_i,
  output int                            fail_count_o,
  output int                            words_due_o
);
  import mcpg_pkg::*;

  typedef struct packed {
    logic [PointW-1:0] px;
    logic [PointW-1:0] py;
    logic [ColorW-1:0] color;
    logic              last;
    logic              done;
    logic              status;
  } point_word_t;

  point_word_t points_due[$];

  // Shadow copy of the circle state.
  logic                        circ_active;
  logic [CoordW-1:0]           ctr_col;
  logic [CoordW-1:0]           ctr_row;
  logic [CoordW-1:0]           cur_x;
  logic [CoordW-1:0]           cur_y;
  logic signed [DecisionW-1:0] decision;
  logic [ColorW-1:0]           circ_color;

  function automatic logic [PointW-1:0] wrap_coord(logic [CoordW-1:0] base,
                                                   logic [CoordW-1:0] offs,
                                                   logic minus);
    logic [PointW-1:0] b;
    logic [PointW-1:0] o;
    b = {{(PointW-CoordW){1'b0}}, base};
    o = {{(PointW-CoordW){1'b0}}, offs};
    return minus ? b - o : b + o;
  endfunction

  task automatic predict_step(input logic op, input logic [CoordW-1:0] cx,
                              input logic [CoordW-1:0] cy,
                              input logic [CoordW-1:0] rad,
                              input logic [ColorW-1:0] col);
    logic [CoordW-1:0] nx;
    logic [CoordW-1:0] ny;
    logic [CoordW-1:0] col_off;
    logic [CoordW-1:0] row_off;
    logic [2:0]        k;
    int                d;
    int                nd;
    logic              done;
    point_word_t       w;
    if (op == OpStart) begin
      ctr_col     = cx;
      ctr_row     = cy;
      cur_x       = '0;
      cur_y       = rad;
      decision    = DecisionW'(1 - int'(rad));
      circ_color  = col;
      circ_active = 1'b1;
    end
    if (!circ_active || cur_x > cur_y) begin
      circ_active = 1'b0;
      w = '{px: '0, py: '0, color: '0, last: 1'b1, done: 1'b0, status: StatusIdle};
      points_due.push_back(w);
    end else begin
      d  = decision;
      nx = cur_x + 1'b1;
      ny = cur_y;
      if (d > 0) begin
        ny = cur_y - 1'b1;
        nd = d + 2 * (int'(nx) - int'(ny)) + 1;
      end else begin
        nd = d + 2 * int'(nx) + 1;
      end
      done = nx > ny;
      // The second half of a step swaps the roles of x and y.
      for (int i = 0; i < 8; i++) begin
        k       = 3'(i);
        col_off = k[2] ? cur_y : cur_x;
        row_off = k[2] ? cur_x : cur_y;
        w.px     = wrap_coord(ctr_col, col_off, k[0]);
        w.py     = wrap_coord(ctr_row, row_off, k[1]);
        w.color  = circ_color;
        w.last   = (k == LastPoint);
        w.done   = done;
        w.status = StatusPoint;
        points_due.push_back(w);
      end
      cur_x    = nx;
      cur_y    = ny;
      decision = DecisionW'(nd);
      if (done) circ_active = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_word_t w;
    if (!rst_ni) begin
      points_due.delete();
      circ_active  = 1'b0;
      ctr_col      = '0;
      ctr_row      = '0;
      cur_x        = '0;
      cur_y        = '0;
      decision     = '0;
      circ_color   = '0;
      fail_count_o = 0;
      words_due_o  = 0;
    end else begin
      if (push && !full) begin
        predict_step(opcode_i, center_x_i, center_y_i, radius_i, color_i);
      end
      if (pop && !empty) begin
        if (points_due.size() == 0) begin
          $error("result word with nothing expected: x 0x%0h y 0x%0h status %0b",
                 point_x_i, point_y_i, status_i);
          fail_count_o++;
        end else begin
          w = points_due.pop_front();
          check_field("point_x", w.px, point_x_i);
          check_field("point_y", w.py, point_y_i);
          check_field("pixel_color", w.color, pixel_color_i);
          check_field("last_of_step", w.last, last_of_step_i);
          check_field("circle_done", w.done, circle_done_i);
          check_field("status", w.status, status_i);
        end
      end
      words_due_o = points_due.size();
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle point generator testbench
// Drives start and advance words into the generator under several idle and
// stall mixes, with one long hold-off on the result side, while the circle
// point monitor predicts and checks every point word.
// ----------------------------------------------------------------------------
module testbench;
  import mcpg_pkg::*;

  // Around 300 words at up to eight results each, even under heavy stalls,
  // finish well inside the limit, which leaves a wide margin.
  localparam int CycleLimit    = 200000;
  localparam int RandomWords   = 270;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 20;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic                opcode = OpStart;
  logic [CoordW-1:0]   center_x = '0;
  logic [CoordW-1:0]   center_y = '0;
  logic [CoordW-1:0]   radius = '0;
  logic [ColorW-1:0]   color = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [PointW-1:0]   point_x;
  logic [PointW-1:0]   point_y;
  logic [ColorW-1:0]   pixel_color;
  logic                last_of_step;
  logic                circle_done;
  logic                status;
  int                  fail_count;
  int                  words_due;

  // Idle mix of the current phase, in percent of cycles.
  int                  send_idle_pct = 0;
  int                  pop_stall_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit                  hold_req = 1'b0;
  int                  hold_left = 0;
  int                  words_sent = 0;
  int                  cycle_count = 0;

  always #6 clk = ~clk;

  midpoint_circle_point_generator DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode),
    .center_x_i     (center_x),
    .center_y_i     (center_y),
    .radius_i       (radius),
    .color_i        (color),
    .empty          (empty),
    .pop            (pop),
    .point_x_o      (point_x),
    .point_y_o      (point_y),
    .pixel_color_o  (pixel_color),
    .last_of_step_o (last_of_step),
    .circle_done_o  (circle_done),
    .status_o       (status)
  );

  circle_point_monitor scoreboard (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .opcode_i       (opcode),
    .center_x_i     (center_x),
    .center_y_i     (center_y),
    .radius_i       (radius),
    .color_i        (color),
    .empty          (empty),
    .pop            (pop),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .pixel_color_i  (pixel_color),
    .last_of_step_i (last_of_step),
    .circle_done_i  (circle_done),
    .status_i       (status),
    .fail_count_o   (fail_count),
    .words_due_o    (words_due)
  );

  // Watchdog. A hung handshake or a point word that never shows up ends the
  // run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Result side. Pop is redrawn every falling edge from the stall mix of the
  // phase. A hold-off request keeps pop low for a long stretch so that the
  // step queue fills and full pushes back on the sender.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // Offers one word and returns at the falling edge after it was taken.
  // Push is written once per falling edge, so a back-to-back word keeps it
  // high without a glitch.
  task automatic send_word(input logic op, input logic [CoordW-1:0] cx,
                           input logic [CoordW-1:0] cy,
                           input logic [CoordW-1:0] rad,
                           input logic [ColorW-1:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push     <= 1'b1;
    opcode   <= op;
    center_x <= cx;
    center_y <= cy;
    radius   <= rad;
    color    <= col;
    // Full is read in the active region after the edge, so it still holds
    // the value that decided acceptance at that edge.
    @(posedge clk);
    while (full) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // An advance carries random bits in the unused fields; the block must
  // ignore them.
  task automatic send_advance();
    send_word(OpAdvance, CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
              ColorW'($urandom));
  endtask

  // One circle with random content. Most circles are small and run to their
  // end, some are cut short by the next start, and some overrun into idle
  // results. A few use the full radius range but only draw a handful of
  // steps, which keeps the run short while still reaching the high radius
  // bits and large decision values.
  task automatic send_circle();
    logic [CoordW-1:0] rad;
    int                steps;
    if ($urandom_range(9) == 0) begin
      rad   = CoordW'($urandom_range(255));
      steps = $urandom_range(8);
    end else begin
      rad   = CoordW'($urandom_range(24));
      // Roughly r / sqrt(2) + 1 steps finish a circle.
      steps = (int'(rad) * 7) / 10 + 1;
      case ($urandom_range(5))
        0: steps = $urandom_range(steps);
        1: steps += $urandom_range(3, 1);
        default: ;
      endcase
    end
    send_word(OpStart, CoordW'($urandom), CoordW'($urandom), rad, ColorW'($urandom));
    repeat (steps) send_advance();
  endtask

  initial begin
    int phase_end;
    // Reset is held from time zero and released on a falling edge.
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed words. An advance straight out of reset has no circle and
    // must give a single idle result.
    send_advance();
    // Zero radius at the origin: the center eight times, but y wraps, so not final.
    send_word(OpStart, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_advance();
    // Largest center, radius and color: positive sums beyond 255.
    send_word(OpStart, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_advance();
    // Origin with the largest radius: differences wrap below zero.
    send_word(OpStart, 8'h00, 8'h00, 8'hFF, 16'h0000);
    send_advance();
    // Radius one runs through both decision branches and ends, then two
    // more advances find no active circle.
    send_word(OpStart, 8'h80, 8'h7F, 8'h01, 16'hA5A5);
    send_advance();
    send_advance();
    send_advance();
    // A start in the middle of a circle abandons the old one.
    send_word(OpStart, 8'h40, 8'hC0, 8'h0A, 16'h5A5A);
    send_advance();
    send_word(OpStart, CoordW'($urandom), CoordW'($urandom), 8'h02, ColorW'($urandom));
    repeat (4) send_advance();

    // Random phases: no idling, sender idle, receiver stalling, then both.
    // The long hold-off falls in the first phase, where the sender pushes
    // every cycle unless full and fills the block fastest.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 56;
          pop_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 56;
        end
        default: begin
          send_idle_pct = 24;
          pop_stall_pct = 24;
        end
      endcase
      if (phase == 0) begin
        push <= 1'b0;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      phase_end = words_sent + RandomWords / 4;
      while (words_sent < phase_end) begin
        // Now and then a stray advance or a lone start as noise.
        case ($urandom_range(9))
          0: send_advance();
          1: send_word(OpStart, CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
                       ColorW'($urandom));
          default: send_circle();
        endcase
      end
    end
    push <= 1'b0;

    // Let every predicted word come out, then watch a few more cycles for
    // anything unexpected. The watchdog bounds this wait.
    while (words_due != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mcpg_pkg.sv
rtl/mcpg_step_fifo.sv
rtl/mcpg_step_sequencer.sv
rtl/mcpg_point_emitter.sv
rtl/midpoint_circle_point_generator.sv
verif/circle_point_monitor.sv
verif/testbench.sv
